### rtl/pu_pkg.sv
// pu_pkg: shared types, constants and factorial tables for the permutation unrank unit
// depends on nothing; imported by every rtl module of the block
`default_nettype none

package pu_pkg;

  localparam int ELEMENT_COUNT = 8;
  localparam int RANK_W        = 16;
  localparam int FIELD_W       = 3;
  localparam int POS_W         = $clog2(ELEMENT_COUNT);
  localparam int FACT_W        = 32;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  typedef logic [ELEMENT_COUNT:0][FACT_W-1:0] fact_tab_t;
  typedef logic [ELEMENT_COUNT-1:0][FACT_W-1:0] mult_row_t;
  typedef logic [ELEMENT_COUNT-1:0][ELEMENT_COUNT-1:0][FACT_W-1:0] mult_tab_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic              out_of_range;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_out_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

  function automatic fact_tab_t build_fact_tab();
    fact_tab_t t;
    t[0] = FACT_W'(1);
    for (int i = 1; i <= ELEMENT_COUNT; i++) begin
      t[i] = t[i-1] * FACT_W'(i);
    end
    return t;
  endfunction

  localparam fact_tab_t FACT_TAB = build_fact_tab();
  localparam logic [FACT_W-1:0] RANK_LIMIT = FACT_TAB[ELEMENT_COUNT];

  // entry [r][k] is k * r!
  function automatic mult_tab_t build_mult_tab();
    mult_tab_t t;
    for (int r = 0; r < ELEMENT_COUNT; r++) begin
      for (int k = 0; k < ELEMENT_COUNT; k++) begin
        t[r][k] = FACT_TAB[r] * FACT_W'(k);
      end
    end
    return t;
  endfunction

  localparam mult_tab_t MULT_TAB = build_mult_tab();

  function automatic logic [FIELD_W-1:0] to_field(logic [POS_W-1:0] v);
    logic [31:0] t;
    t = 32'(v);
    return t[FIELD_W-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/pu_front.sv
// pu_front: accepts ranks and flags those at or above the element count factorial
// depends on pu_pkg
`default_nettype none

module pu_front (
  input  wire logic                  start,
  input  wire logic [pu_pkg::RANK_W-1:0] rank,
  input  wire logic                  queue_full,
  output logic                       busy,
  output logic                       push,
  output pu_pkg::item_t              push_item
);
  import pu_pkg::*;

  assign busy = queue_full;
  assign push = start && !queue_full;

  always_comb begin
    push_item.rank         = rank;
    push_item.out_of_range = (FACT_W'(rank) >= RANK_LIMIT);
  end

endmodule

`default_nettype wire

### rtl/pu_queue.sv
// pu_queue: short item queue between the front and the back sequencer
// depends on pu_pkg
`default_nettype none

module pu_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire pu_pkg::item_t push_item,
  input  wire logic          pop,
  output logic               full,
  output pu_pkg::queue_out_t head
);
  import pu_pkg::*;

  item_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  cnt;
  logic               do_pop;

  assign full       = (cnt == QCNT_W'(QUEUE_DEPTH));
  assign head.valid = (cnt != '0);
  assign head.item  = mem[rd_ptr];
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !do_pop) begin
        cnt <= cnt + QCNT_W'(1);
      end else if (do_pop && !push) begin
        cnt <= cnt - QCNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("queue written while full");

  a_no_blind_pop: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("queue popped while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule

`default_nettype wire

### rtl/pu_back.sv
// pu_back: position sequencer, one factorial digit and one element pick per cycle
// depends on pu_pkg; takes items from pu_queue
`default_nettype none

module pu_back (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire pu_pkg::queue_out_t     head,
  output logic                        pop,
  output logic                        valid,
  output logic [pu_pkg::FIELD_W-1:0]  element,
  output logic [pu_pkg::FIELD_W-1:0]  position,
  output logic                        last,
  output logic                        out_of_range
);
  import pu_pkg::*;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(ELEMENT_COUNT - 1);

  back_state_t              state;
  back_state_t              state_next;
  logic [RANK_W-1:0]        rem;
  logic [ELEMENT_COUNT-1:0] used;
  logic [POS_W-1:0]         pos;
  logic                     oor;

  logic                     done;
  logic                     step;
  logic [POS_W-1:0]         right;
  mult_row_t                row;
  logic [POS_W-1:0]         q;
  logic [POS_W-1:0]         pick;
  logic [POS_W-1:0]         seen;
  logic                     found;

  assign done  = oor || (pos == LAST_POS);
  assign right = LAST_POS - pos;

  // digit of the remaining rank and the matching unused value
  always_comb begin
    row = MULT_TAB[right];
    q   = '0;
    for (int k = 1; k < ELEMENT_COUNT; k++) begin
      if ((k <= int'(right)) && (FACT_W'(rem) >= row[k])) begin
        q = q + POS_W'(1);
      end
    end
    pick  = '0;
    seen  = '0;
    found = 1'b0;
    for (int v = 0; v < ELEMENT_COUNT; v++) begin
      if (!used[v] && !found) begin
        if (seen == q) begin
          pick  = POS_W'(v);
          found = 1'b1;
        end else begin
          seen = seen + POS_W'(1);
        end
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (head.valid) begin
          state_next = BK_RUN;
        end
      end
      BK_RUN: begin
        if (done && !head.valid) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    step = 1'b0;
    pop  = 1'b0;
    unique case (state)
      BK_IDLE: begin
        pop = head.valid;
      end
      BK_RUN: begin
        step = 1'b1;
        pop  = done && head.valid;
      end
      default: begin
        step = 1'b0;
        pop  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      valid <= 1'b0;
    end else begin
      state <= state_next;
      valid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rem  <= head.item.rank;
      used <= '0;
      pos  <= '0;
      oor  <= head.item.out_of_range;
    end else if (step) begin
      rem  <= rem - row[q][RANK_W-1:0];
      used <= used | (ELEMENT_COUNT'(1) << pick);
      pos  <= pos + POS_W'(1);
    end
    if (step) begin
      element      <= oor ? '0 : to_field(pick);
      position     <= oor ? '0 : to_field(pos);
      last         <= done;
      out_of_range <= oor;
    end
  end

  a_err_single: assert property (@(posedge clk) disable iff (rst)
    (valid && out_of_range) |-> (last && element == '0 && position == '0))
    else $error("error item not a single zero result");

  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    (valid && !last) |=> valid)
    else $error("gap inside a permutation");

  a_pos_order: assert property (@(posedge clk) disable iff (rst)
    (valid && !last) |=> (position == $past(position) + FIELD_W'(1)))
    else $error("positions out of order");

  a_pick_free: assert property (@(posedge clk) disable iff (rst)
    (step && !oor) |-> (found && !used[pick]))
    else $error("picked value already used");

endmodule

`default_nettype wire

### rtl/permutation_unrank_unit.sv
// permutation_unrank_unit: rank in, permutation elements out one position per cycle
// depends on pu_pkg, pu_front, pu_queue, pu_back
//
// channel  | handshake          | payload
// ---------+--------------------+-------------------------------------------
// in       | start & !busy      | rank[15:0]
// out      | valid (one cycle)  | element[2:0] position[2:0] last out_of_range
//
// a rank in range gives ELEMENT_COUNT results on consecutive cycles, one per
// position, set by the back sequencer's position counter; an out-of-range rank
// gives one result; from an idle sequencer a taken rank is queued, loaded, then
// its first result is registered; a running sequencer loads the next queued rank
// as it registers the last result; the two-entry queue takes ranks while the
// sequencer works, busy is high only when that queue is full
// results cannot be held off, so nothing stalls the sequencer
// rst is synchronous; after it the queue is empty and no result is shown
`default_nettype none

module permutation_unrank_unit (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [pu_pkg::RANK_W-1:0]    rank,
  output logic                              valid,
  output logic [pu_pkg::FIELD_W-1:0]        element,
  output logic [pu_pkg::FIELD_W-1:0]        position,
  output logic                              last,
  output logic                              out_of_range
);
  import pu_pkg::*;

  logic       queue_full;
  logic       push;
  item_t      push_item;
  logic       pop;
  queue_out_t head;

  pu_front u_front (
    .start      (start),
    .rank       (rank),
    .queue_full (queue_full),
    .busy       (busy),
    .push       (push),
    .push_item  (push_item)
  );

  pu_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (queue_full),
    .head      (head)
  );

  pu_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .pop          (pop),
    .valid        (valid),
    .element      (element),
    .position     (position),
    .last         (last),
    .out_of_range (out_of_range)
  );

endmodule

`default_nettype wire

### tb/tb.sv
// tb: self-checking bench for permutation_unrank_unit, ranks in, permutation elements out
// depends on pu_pkg and the rtl of the block; predicts every element and checks it in order
`default_nettype none

module tb;

  import pu_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 24;

  typedef struct packed {
    logic [FIELD_W-1:0] element;
    logic [FIELD_W-1:0] position;
    logic               last;
    logic               out_of_range;
  } perm_digit_t;

  typedef struct packed {
    logic              drain;
    logic [RANK_W-1:0] rank;
  } rank_item_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [RANK_W-1:0]  rank = '0;
  logic               busy;
  logic               valid;
  logic [FIELD_W-1:0] element;
  logic [FIELD_W-1:0] position;
  logic               last;
  logic               out_of_range;

  rank_item_t  pending_ranks[$];
  perm_digit_t expected_digits[$];

  int item_total = 0;
  int presented = 0;
  int ranks_taken = 0;
  int oor_taken = 0;
  int digits_checked = 0;
  int errors = 0;
  int cycles = 0;

  permutation_unrank_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .rank         (rank),
    .valid        (valid),
    .element      (element),
    .position     (position),
    .last         (last),
    .out_of_range (out_of_range)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint fact_of(int k);
    longint f;
    f = 1;
    for (int i = 2; i <= k; i++) begin
      f = f * i;
    end
    return f;
  endfunction

  // expected elements of the permutation at rank r, left to right, or one out-of-range result
  task automatic unrank_expect(input logic [RANK_W-1:0] r);
    int          n;
    longint      rem;
    longint      f;
    longint      q;
    longint      seen;
    int          pick;
    logic [31:0] taken;
    perm_digit_t d;
    n = ELEMENT_COUNT;
    if (n < 1) n = 1;
    if (n > 12) n = 12;
    rem = longint'(r);
    taken = '0;
    if (rem >= fact_of(n)) begin
      d.element = '0;
      d.position = '0;
      d.last = 1'b1;
      d.out_of_range = 1'b1;
      expected_digits.push_back(d);
    end else begin
      for (int pos = 0; pos < n; pos++) begin
        f = fact_of(n - 1 - pos);
        q = rem / f;
        rem = rem % f;
        pick = 0;
        seen = 0;
        for (int v = 0; v < n; v++) begin
          if (!taken[v]) begin
            if (seen == q) begin
              pick = v;
              break;
            end
            seen++;
          end
        end
        taken[pick] = 1'b1;
        d.element = FIELD_W'(pick);
        d.position = FIELD_W'(pos);
        d.last = (pos == n - 1);
        d.out_of_range = 1'b0;
        expected_digits.push_back(d);
      end
    end
  endtask

  function automatic void field_check(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // driver: start held until the item is taken, then the next rank after a random gap, none in the last third
  always @(posedge clk) begin : drive
    logic              nxt_start;
    logic [RANK_W-1:0] nxt_rank;
    int                idle_pct;
    nxt_start = start;
    nxt_rank = rank;
    if (rst) begin
      nxt_start = 1'b0;
    end else if (!start || !busy) begin
      nxt_start = 1'b0;
      if (presented < item_total / 3) idle_pct = 27;
      else if (presented < 2 * item_total / 3) idle_pct = 49;
      else idle_pct = 0;
      if (pending_ranks.size() > 0 &&
          !(pending_ranks[0].drain &&
            (expected_digits.size() != 0 || (start && !busy))) &&
          $urandom_range(99) >= idle_pct) begin
        nxt_start = 1'b1;
        nxt_rank = pending_ranks[0].rank;
        void'(pending_ranks.pop_front());
        presented++;
      end
    end
    start <= nxt_start;
    rank <= nxt_rank;
  end

  // monitor: check results against the oldest expectation, then record newly taken ranks
  always @(posedge clk) begin : monitor
    perm_digit_t want;
    if (!rst) begin
      if (valid) begin
        if (expected_digits.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0d/%0d/%0b/%0b",
                   $time, element, position, last, out_of_range);
          errors++;
        end else begin
          want = expected_digits.pop_front();
          field_check("element", want.element, element);
          field_check("position", want.position, position);
          field_check("last", want.last, last);
          field_check("out_of_range", want.out_of_range, out_of_range);
          digits_checked++;
        end
      end
      if (start && !busy) begin
        unrank_expect(rank);
        ranks_taken++;
        if (rank >= RANK_LIMIT) oor_taken++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycles, expected_digits.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [RANK_W-1:0] directed [24];
    rank_item_t        it;
    int                n_random;
    directed = '{16'd0, 16'd1, 16'd2, 16'd5, 16'd6, 16'd23, 16'd24, 16'd119,
                 16'd120, 16'd719, 16'd720, 16'd5039, 16'd5040, 16'd20160,
                 16'd40318, 16'd40319, 16'd40320, 16'd40321, 16'd43690,
                 16'd21845, 16'd32768, 16'd65535, 16'd1023, 16'd65534};
    foreach (directed[i]) begin
      it.drain = 1'b0;
      it.rank = directed[i];
      pending_ranks.push_back(it);
    end
    n_random = 406;
    for (int i = 0; i < n_random; i++) begin
      it.drain = (i == 0) || (i == n_random / 3) || (i == 2 * n_random / 3);
      case ($urandom_range(9))
        8: it.rank = RANK_W'($urandom_range(65535, 40320));
        9: it.rank = RANK_W'(longint'($urandom_range(7, 1)) * fact_of($urandom_range(7))
                             - $urandom_range(1));
        default: it.rank = RANK_W'($urandom_range(40319));
      endcase
      pending_ranks.push_back(it);
    end
    item_total = pending_ranks.size();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    while (pending_ranks.size() != 0 || start || expected_digits.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_WAIT) @(negedge clk);
    $display("covered %0d ranks, %0d of them out of range, %0d elements checked",
             ranks_taken, oor_taken, digits_checked);
    $display("sender pacing went through gaps of 27 and 49 percent, then back to back");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
rtl/pu_pkg.sv
rtl/pu_front.sv
rtl/pu_queue.sv
rtl/pu_back.sv
rtl/permutation_unrank_unit.sv
tb/tb.sv
